@@ design/u8d_pkg.sv @@
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types, state codes and lookup tables for the UTF-8 DFA decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

  localparam int BYTE_W   = 8;
  localparam int CLASS_W  = 4;
  localparam int STATE_W  = 4;
  localparam int CP_W     = 21;
  localparam int ACC_BITS = 6;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [STATE_W-1:0] ST_ACCEPT = 4'd0;
  localparam logic [STATE_W-1:0] ST_REJECT = 4'd1;
  localparam logic [STATE_W-1:0] ST_LAST   = 4'd8;

  localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

  // classified byte handed from the front to the back
  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic [CLASS_W-1:0] cls;
  } tok_t;

  // next state, indexed by {state, class}; rows for states 0..8
  localparam logic [STATE_W-1:0] NEXT_STATE [144] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1,
    4'd1, 4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0,
    4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
    4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
    4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
    4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
  };

  // byte class table, written as ranges
  function automatic logic [CLASS_W-1:0] byte_class(input logic [BYTE_W-1:0] b);
    logic [CLASS_W-1:0] c;
    priority if (b <= 8'h7F) c = 4'd0;
    else if (b <= 8'h8F)     c = 4'd1;
    else if (b <= 8'h9F)     c = 4'd9;
    else if (b <= 8'hBF)     c = 4'd7;
    else if (b <= 8'hC1)     c = 4'd8;
    else if (b <= 8'hDF)     c = 4'd2;
    else if (b == 8'hE0)     c = 4'd10;
    else if (b == 8'hED)     c = 4'd4;
    else if (b <= 8'hEF)     c = 4'd3;
    else if (b == 8'hF0)     c = 4'd11;
    else if (b <= 8'hF3)     c = 4'd6;
    else if (b == 8'hF4)     c = 4'd5;
    else                     c = 4'd8;
    return c;
  endfunction

  function automatic logic [STATE_W-1:0] next_state(input logic [STATE_W-1:0] s,
                                                    input logic [CLASS_W-1:0] c);
    logic [7:0] idx;
    idx = {s, c};
    return NEXT_STATE[idx];
  endfunction

endpackage

`default_nettype wire

@@ design/u8d_front.sv @@
// ----------------------------------------------------------------------------
// u8d_front
// Input stage: takes one byte per item and registers it with its class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8d_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [u8d_pkg::BYTE_W-1:0] byte_in,
  output logic                            tok_valid,
  input  wire logic                       tok_stall,
  output u8d_pkg::tok_t                   tok
);

  logic f_valid;

  assign in_stall  = f_valid && tok_stall;
  assign tok_valid = f_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!in_stall) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      tok.data <= byte_in;
      tok.cls  <= u8d_pkg::byte_class(byte_in);
    end
  end

endmodule

`default_nettype wire

@@ design/u8d_queue.sv @@
// ----------------------------------------------------------------------------
// u8d_queue
// Short FIFO of classified items between the front and back stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8d_queue #(
  parameter int DEPTH = u8d_pkg::QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire u8d_pkg::tok_t in_tok,
  output logic               out_valid,
  input  wire logic          out_stall,
  output u8d_pkg::tok_t      out_tok,
  output logic [CNT_W-1:0]   level
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  u8d_pkg::tok_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_stall  = (count == CNT_FULL);
  assign out_valid = (count != '0);
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign out_tok   = slots[rd_ptr];
  assign level     = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_tok;
    end
  end

endmodule

`default_nettype wire

@@ design/u8d_back.sv @@
// ----------------------------------------------------------------------------
// u8d_back
// DFA step: updates state and partial code point, drives the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8d_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  output logic                             q_stall,
  input  wire u8d_pkg::tok_t               q_tok,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [u8d_pkg::CP_W-1:0]         code_point,
  output logic                             complete,
  output logic                             rejected,
  output logic [u8d_pkg::STATE_W-1:0]      machine_state
);

  logic [u8d_pkg::STATE_W-1:0] dfa_state;
  logic [u8d_pkg::CP_W-1:0]    partial_cp;
  logic [u8d_pkg::STATE_W-1:0] cur;
  logic [u8d_pkg::STATE_W-1:0] state_next;
  logic [u8d_pkg::CP_W-1:0]    cp_next;
  logic [u8d_pkg::BYTE_W-1:0]  lead_mask;
  logic                        pop;

  assign q_stall = out_valid && out_stall;
  assign pop     = q_valid && !q_stall;

  always_comb begin
    // states past the last one fall into reject
    cur        = (dfa_state > u8d_pkg::ST_LAST) ? u8d_pkg::ST_REJECT : dfa_state;
    lead_mask  = 8'hFF >> q_tok.cls;
    state_next = u8d_pkg::next_state(cur, q_tok.cls);
    if (cur == u8d_pkg::ST_ACCEPT) begin
      cp_next = {13'd0, lead_mask & q_tok.data};
    end else begin
      cp_next = {partial_cp[u8d_pkg::CP_W-u8d_pkg::ACC_BITS-1:0],
                 q_tok.data[u8d_pkg::ACC_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dfa_state  <= u8d_pkg::ST_ACCEPT;
      partial_cp <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        dfa_state  <= state_next;
        partial_cp <= cp_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      code_point    <= cp_next;
      complete      <= (state_next == u8d_pkg::ST_ACCEPT);
      rejected      <= (state_next == u8d_pkg::ST_REJECT);
      machine_state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ design/utf8_dfa_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_dfa_decoder
// UTF-8 byte stream decoder: byte classifier, item queue and DFA back end.
// ----------------------------------------------------------------------------
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   in       | in_valid / in_stall  | byte_in
//   out      | out_valid / out_stall| code_point, complete, rejected, machine_state
//
// One item per cycle sustained while the output is not stalled; an accepted
// byte passes the class register, then a queue slot, then the output register.
// The DFA state and partial code point registers loop through the table lookup.
// Reset returns the DFA to accept and empties the queue and output register.
// A stalled output holds its result; the queue absorbs the front's item while
// the back end waits, and the input stalls only once the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_dfa_decoder #(
  parameter int QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [u8d_pkg::BYTE_W-1:0]  byte_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [u8d_pkg::CP_W-1:0]         code_point,
  output logic                             complete,
  output logic                             rejected,
  output logic [u8d_pkg::STATE_W-1:0]      machine_state
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             f_valid;
  logic             f_stall;
  u8d_pkg::tok_t    f_tok;
  logic             q_valid;
  logic             q_stall;
  u8d_pkg::tok_t    q_tok;
  logic [CNT_W-1:0] q_level;

  u8d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .byte_in   (byte_in),
    .tok_valid (f_valid),
    .tok_stall (f_stall),
    .tok       (f_tok)
  );

  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_stall  (f_stall),
    .in_tok    (f_tok),
    .out_valid (q_valid),
    .out_stall (q_stall),
    .out_tok   (q_tok),
    .level     (q_level)
  );

  u8d_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_stall       (q_stall),
    .q_tok         (q_tok),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .code_point    (code_point),
    .complete      (complete),
    .rejected      (rejected),
    .machine_state (machine_state)
  );

  // queue never holds more than its depth
  a_queue_level: assert property (@(posedge clk) disable iff (rst)
    q_level <= CNT_W'(QUEUE_DEPTH))
    else $error("queue level above depth");

  // a taken reject result is directly followed by no valid result or by a reject
  a_reject_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && rejected) |=> (!out_valid || rejected))
    else $error("reject flag cleared without reset");

  // a finished code point is always in the Unicode range
  a_cp_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && complete) |-> (code_point <= u8d_pkg::CP_MAX))
    else $error("completed code point out of range");

  // the front stalls only while the queue is full
  a_front_stall: assert property (@(posedge clk) disable iff (rst)
    (f_valid && f_stall) |-> (q_level == CNT_W'(QUEUE_DEPTH)))
    else $error("front stalled with room in queue");

endmodule

`default_nettype wire
